// ===== hdl/lrup_pkg.sv =====
package lrup_pkg;

    localparam int PAGE_FIELD_W = 16;
    localparam int SLOT_FIELD_W = 3;
    localparam int FAULT_W      = 32;
    localparam int CFG_W        = 4;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int RANK_W       = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [RANK_W-1:0]     RANK_CAP      = 8'hFF;
    localparam logic [FAULT_W-1:0]    FAULT_MAX     = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0]      FRAMES_RESET  = 4'd4;
    localparam logic [APB_ADDR_W-1:2] REG_ACTIVE_FRAMES = 1'b0;

    typedef struct packed {
        logic [PAGE_FIELD_W-1:0] page_number;
        logic                    end_of_string;
    } ref_beat_t;

    typedef struct packed {
        logic                    hit;
        logic [SLOT_FIELD_W-1:0] frame_slot;
        logic                    evicted_valid;
        logic [PAGE_FIELD_W-1:0] evicted_page;
        logic [FAULT_W-1:0]      fault_total;
        logic                    run_done;
    } res_beat_t;

    typedef struct packed {
        logic      valid;
        ref_beat_t beat;
    } queue_head_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_COMMIT
    } back_state_t;

endpackage

// ===== hdl/lrup_front.sv =====
module lrup_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ref_valid,
    output logic               ref_stall,
    input  lrup_pkg::ref_beat_t ref_beat,
    output lrup_pkg::queue_head_t q_head,
    input  logic               q_pop
);
    import lrup_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ref_beat_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign ref_stall    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push         = ref_valid && !ref_stall;
    assign pop          = q_pop && (count_reg != '0);
    assign q_head.valid = (count_reg != '0);
    assign q_head.beat  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= ref_beat;
        end
    end

endmodule

// ===== hdl/lrup_back.sv =====
module lrup_back #(
    parameter int MAX_FRAMES = 8,
    parameter int STORE_BITS = 16,
    parameter int IDX_W      = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      last_idx,
    input  lrup_pkg::queue_head_t q_head,
    output logic                  q_pop,
    output logic                  res_valid,
    input  logic                  res_stall,
    output lrup_pkg::res_beat_t   res_beat
);
    import lrup_pkg::*;

    back_state_t           state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [STORE_BITS-1:0] page_reg, page_next;
    logic                  last_reg, last_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      hit_slot_reg, hit_slot_next;
    logic                  empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]      empty_slot_reg, empty_slot_next;
    logic [RANK_W-1:0]     best_reg, best_next;
    logic [IDX_W-1:0]      vict_slot_reg, vict_slot_next;
    logic [STORE_BITS-1:0] vict_page_reg, vict_page_next;
    logic                  valid_reg [MAX_FRAMES];
    logic                  valid_next [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_reg [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_next [MAX_FRAMES];
    logic [FAULT_W-1:0]    fault_reg, fault_next;
    logic [FAULT_W-1:0]    fault_inc;
    logic                  out_valid_reg, out_valid_next;
    res_beat_t             out_reg, out_next;
    logic [IDX_W-1:0]      slot;
    logic                  mem_we;

    logic [STORE_BITS-1:0] page_mem [MAX_FRAMES];
    logic [STORE_BITS-1:0] rd_data_reg;

    assign res_valid = out_valid_reg;
    assign res_beat  = out_reg;

    assign slot      = found_reg ? hit_slot_reg :
                       (empty_found_reg ? empty_slot_reg : vict_slot_reg);
    assign fault_inc = (found_reg || fault_reg == FAULT_MAX) ? fault_reg : fault_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        page_next        = page_reg;
        last_next        = last_reg;
        found_next       = found_reg;
        hit_slot_next    = hit_slot_reg;
        empty_found_next = empty_found_reg;
        empty_slot_next  = empty_slot_reg;
        best_next        = best_reg;
        vict_slot_next   = vict_slot_reg;
        vict_page_next   = vict_page_reg;
        valid_next       = valid_reg;
        rank_next        = rank_reg;
        fault_next       = fault_reg;
        out_valid_next   = out_valid_reg && res_stall;
        out_next         = out_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop            = 1'b1;
                    page_next        = q_head.beat.page_number[STORE_BITS-1:0];
                    last_next        = q_head.beat.end_of_string;
                    idx_next         = '0;
                    found_next       = 1'b0;
                    hit_slot_next    = '0;
                    empty_found_next = 1'b0;
                    empty_slot_next  = '0;
                    best_next        = '0;
                    vict_slot_next   = '0;
                    state_next       = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (!found_reg && valid_reg[idx_reg] && rd_data_reg == page_reg)
                begin
                    found_next    = 1'b1;
                    hit_slot_next = idx_reg;
                end
                if (!empty_found_reg && !valid_reg[idx_reg])
                begin
                    empty_found_next = 1'b1;
                    empty_slot_next  = idx_reg;
                end
                if (idx_reg == '0 || rank_reg[idx_reg] > best_reg)
                begin
                    best_next      = rank_reg[idx_reg];
                    vict_slot_next = idx_reg;
                    vict_page_next = rd_data_reg;
                end
                if (idx_reg == last_idx)
                begin
                    state_next = BK_COMMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_COMMIT:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_next.hit           = found_reg;
                    out_next.frame_slot    = SLOT_FIELD_W'(slot);
                    out_next.evicted_valid = !found_reg && !empty_found_reg;
                    out_next.evicted_page  = (!found_reg && !empty_found_reg) ?
                                             PAGE_FIELD_W'(vict_page_reg) : '0;
                    out_next.fault_total   = fault_inc;
                    out_next.run_done      = last_reg;
                    fault_next             = fault_inc;
                    if (!found_reg)
                    begin
                        mem_we           = 1'b1;
                        valid_next[slot] = 1'b1;
                    end
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        if (IDX_W'(i) != slot && IDX_W'(i) <= last_idx && valid_reg[i] &&
                            (!found_reg || rank_reg[i] < rank_reg[slot]) &&
                            rank_reg[i] != RANK_CAP)
                        begin
                            rank_next[i] = rank_reg[i] + 1'b1;
                        end
                    end
                    rank_next[slot] = '0;
                    if (last_reg)
                    begin
                        fault_next = '0;
                        for (int i = 0; i < MAX_FRAMES; i++)
                        begin
                            valid_next[i] = 1'b0;
                            rank_next[i]  = '0;
                        end
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            fault_reg       <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            found_reg       <= found_next;
            empty_found_reg <= empty_found_next;
            fault_reg       <= fault_next;
            out_valid_reg   <= out_valid_next;
            valid_reg       <= valid_next;
            rank_reg        <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        page_reg       <= page_next;
        last_reg       <= last_next;
        hit_slot_reg   <= hit_slot_next;
        empty_slot_reg <= empty_slot_next;
        best_reg       <= best_next;
        vict_slot_reg  <= vict_slot_next;
        vict_page_reg  <= vict_page_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[slot] <= page_reg;
        end
        rd_data_reg <= page_mem[idx_next];
    end

endmodule

// ===== hdl/lru_page_replacement.sv =====
// A reference beat waits in a two-entry queue in the front end; the back-end
// sequencer then pops it, reads the n active frames (n from 1 to MAX_FRAMES)
// one per cycle from the page memory and commits its result beat, waiting while
// a previous result beat is still stalled. It pops the next beat after that commit.
// Reset: all frames empty, ranks and fault count zero, active_frames is 4.
module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ref_valid,
    output logic                                ref_stall,
    input  lrup_pkg::ref_beat_t                 ref_beat,
    output logic                                res_valid,
    input  logic                                res_stall,
    output lrup_pkg::res_beat_t                 res_beat,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrup_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lrup_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lrup_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lrup_pkg::*;

    localparam int STORE_BITS = (PAGE_BITS < PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [CFG_W-1:0] active_frames_reg, active_frames_next;
    logic [IDX_W-1:0] last_idx;
    logic             reg_sel;
    queue_head_t      q_head;
    logic             q_pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_ACTIVE_FRAMES);
    assign prdata  = reg_sel ? APB_DATA_W'(active_frames_reg) : '0;

    always_comb
    begin
        active_frames_next = active_frames_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            active_frames_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_frames_reg <= FRAMES_RESET;
        end
        else
        begin
            active_frames_reg <= active_frames_next;
        end
    end

    always_comb
    begin
        if (active_frames_reg == '0)
        begin
            last_idx = '0;
        end
        else if (int'(active_frames_reg) >= MAX_FRAMES)
        begin
            last_idx = IDX_W'(MAX_FRAMES - 1);
        end
        else
        begin
            last_idx = IDX_W'(active_frames_reg - 1'b1);
        end
    end

    lrup_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ref_valid (ref_valid),
        .ref_stall (ref_stall),
        .ref_beat  (ref_beat),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    lrup_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .STORE_BITS (STORE_BITS),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .last_idx  (last_idx),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule

// ===== dv/tb_lru_page_replacement.sv =====
`timescale 1ns / 100ps

module tb_lru_page_replacement;

    import lrup_pkg::*;

    localparam int N_FRAMES     = 8;
    localparam int N_PAGE_BITS  = 16;
    localparam int DRAIN_CYCLES = N_FRAMES + 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int WSET_MAX     = 12;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  ref_valid = 1'b0;
    logic                  ref_stall;
    ref_beat_t             ref_beat  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_beat_t             res_beat;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ref_beat_t pending_refs[$];
    res_beat_t lru_expected[$];

    logic [PAGE_FIELD_W-1:0] fr_page[N_FRAMES];
    logic                    fr_valid[N_FRAMES];
    logic [RANK_W-1:0]       fr_rank[N_FRAMES];
    logic [FAULT_W-1:0]      faults;
    logic [CFG_W-1:0]        cfg_frames;

    int  errors          = 0;
    int  refs_sent       = 0;
    int  refs_taken      = 0;
    int  results_seen    = 0;
    int  sender_idle_pct = 0;
    int  recv_idle_pct   = 0;
    int  hold_go         = 0;
    int  hold_seen       = 0;
    int  hold_left       = 0;
    logic ref_taken      = 1'b0;

    lru_page_replacement #(
        .MAX_FRAMES (N_FRAMES),
        .PAGE_BITS  (N_PAGE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ref_valid (ref_valid),
        .ref_stall (ref_stall),
        .ref_beat  (ref_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
        errors++;
    endtask

    function automatic void clear_frames();
        for (int i = 0; i < N_FRAMES; i++)
        begin
            fr_page[i]  = '0;
            fr_valid[i] = 1'b0;
            fr_rank[i]  = '0;
        end
        faults = '0;
    endfunction

    // Touched frame gets youngest; valid frames below limit (all if no_limit) age by one.
    function automatic void age_frames(input int n, input int s, input bit no_limit,
                                       input logic [RANK_W-1:0] limit);
        for (int i = 0; i < n; i++)
        begin
            if (i != s && fr_valid[i] && (no_limit || fr_rank[i] < limit) &&
                fr_rank[i] < RANK_CAP)
                fr_rank[i] = fr_rank[i] + 1'b1;
        end
        fr_rank[s] = '0;
    endfunction

    function automatic res_beat_t lru_lookup(input ref_beat_t b);
        res_beat_t         r;
        int                n;
        int                slot;
        bit                found;
        bit                empty;
        logic [RANK_W-1:0] best;
        logic [PAGE_FIELD_W-1:0] pg;
        r     = '0;
        pg    = b.page_number;
        n     = (cfg_frames == 0) ? 1 : ((cfg_frames > N_FRAMES) ? N_FRAMES : int'(cfg_frames));
        slot  = 0;
        found = 1'b0;
        empty = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && fr_valid[i] && fr_page[i] == pg)
            begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found)
            age_frames(n, slot, 1'b0, fr_rank[slot]);
        else
        begin
            if (faults != FAULT_MAX)
                faults = faults + 1'b1;
            for (int i = 0; i < n; i++)
            begin
                if (!empty && !fr_valid[i])
                begin
                    slot  = i;
                    empty = 1'b1;
                end
            end
            if (empty)
            begin
                fr_valid[slot] = 1'b1;
                fr_page[slot]  = pg;
            end
            else
            begin
                best = '0;
                slot = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (fr_rank[i] > best)
                    begin
                        best = fr_rank[i];
                        slot = i;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = fr_page[slot];
                fr_page[slot]   = pg;
            end
            age_frames(n, slot, 1'b1, '0);
        end
        r.hit         = found;
        r.frame_slot  = 3'(slot);
        r.fault_total = faults;
        r.run_done    = b.end_of_string;
        if (b.end_of_string)
            clear_frames();
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            ref_valid <= 1'b0;
            ref_beat  <= '0;
        end
        else if (!ref_valid || ref_taken)
        begin
            if (pending_refs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                ref_beat  <= pending_refs.pop_front();
                ref_valid <= 1'b1;
            end
            else
                ref_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            res_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        res_beat_t want;
        ref_taken <= rst_n && ref_valid && !ref_stall;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (lru_expected.size() == 0)
                    log_mismatch("beat with nothing pending, fault_total",
                                 res_beat.fault_total, 32'd0);
                else
                begin
                    want = lru_expected.pop_front();
                    if (res_beat.hit !== want.hit)
                        log_mismatch("hit", 32'(res_beat.hit), 32'(want.hit));
                    if (res_beat.frame_slot !== want.frame_slot)
                        log_mismatch("frame_slot", 32'(res_beat.frame_slot),
                                     32'(want.frame_slot));
                    if (res_beat.evicted_valid !== want.evicted_valid)
                        log_mismatch("evicted_valid", 32'(res_beat.evicted_valid),
                                     32'(want.evicted_valid));
                    if (res_beat.evicted_page !== want.evicted_page)
                        log_mismatch("evicted_page", 32'(res_beat.evicted_page),
                                     32'(want.evicted_page));
                    if (res_beat.fault_total !== want.fault_total)
                        log_mismatch("fault_total", res_beat.fault_total, want.fault_total);
                    if (res_beat.run_done !== want.run_done)
                        log_mismatch("run_done", 32'(res_beat.run_done), 32'(want.run_done));
                end
                results_seen++;
            end
            if (ref_valid && !ref_stall)
            begin
                lru_expected.push_back(lru_lookup(ref_beat));
                refs_taken++;
            end
        end
    end

    task automatic queue_ref(input logic [PAGE_FIELD_W-1:0] page, input logic eos);
        ref_beat_t b;
        b.page_number   = page;
        b.end_of_string = eos;
        pending_refs.push_back(b);
        refs_sent++;
    endtask

    task automatic wait_idle();
        while (refs_taken != refs_sent || lru_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic read_frames_reg();
        logic [APB_DATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_ACTIVE_FRAMES, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[CFG_W-1:0] !== cfg_frames)
            log_mismatch("active_frames readback", 32'(got[CFG_W-1:0]), 32'(cfg_frames));
    endtask

    task automatic write_frames_reg(input logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ACTIVE_FRAMES, 2'b00};
        pwdata  <= {(APB_DATA_W - CFG_W)'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_frames = value;
        read_frames_reg();
    endtask

    initial
    begin : stimulus
        logic [PAGE_FIELD_W-1:0] wset[WSET_MAX];
        logic [PAGE_FIELD_W-1:0] pg;
        logic [CFG_W-1:0]        frames_pick[6];
        int                      ws;
        int                      pick;
        frames_pick = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9};
        clear_frames();
        cfg_frames = FRAMES_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 22;
        recv_idle_pct   = 67;
        read_frames_reg();

        @(posedge clk);
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'hFFFF, 1'b0);
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'h1234, 1'b0);
        queue_ref(16'h8000, 1'b0);
        queue_ref(16'h5555, 1'b0);
        queue_ref(16'hFFFF, 1'b0);
        queue_ref(16'h8000, 1'b0);
        queue_ref(16'hAAAA, 1'b1);
        queue_ref(16'h0001, 1'b0);
        wait_idle();
        write_frames_reg(4'd2);
        @(posedge clk);
        queue_ref(16'h0002, 1'b0);
        wait_idle();
        // Shrinking to one frame lets the same page land in two frames.
        write_frames_reg(4'd1);
        @(posedge clk);
        queue_ref(16'h0002, 1'b0);
        wait_idle();
        write_frames_reg(4'd2);
        @(posedge clk);
        queue_ref(16'h0002, 1'b0);
        queue_ref(16'h0001, 1'b1);
        wait_idle();
        write_frames_reg(4'd0);
        @(posedge clk);
        queue_ref(16'h7777, 1'b0);
        queue_ref(16'h7778, 1'b0);
        queue_ref(16'h7777, 1'b1);
        wait_idle();
        write_frames_reg(4'd15);
        @(posedge clk);
        for (int i = 0; i < 9; i++)
            queue_ref(16'h0100 + 16'(i), i == 8);
        wait_idle();

        for (int phase = 0; phase < 24; phase++)
        begin
            if (phase < 8)
            begin
                sender_idle_pct = 22;
                recv_idle_pct   = 67;
            end
            else if (phase < 16)
            begin
                sender_idle_pct = 67;
                recv_idle_pct   = 22;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            if (phase < 6)
                write_frames_reg(frames_pick[phase]);
            else
                write_frames_reg(4'($urandom_range(0, 15)));
            ws = $urandom_range(1, WSET_MAX);
            for (int k = 0; k < WSET_MAX; k++)
                wset[k] = 16'($urandom());
            @(posedge clk);
            for (int i = 0; i < 62; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    pg = wset[$urandom_range(0, ws - 1)];
                else if (pick < 90)
                    pg = 16'($urandom());
                else
                    pg = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                queue_ref(pg, $urandom_range(0, 29) == 0);
            end
            if (phase == 3)
                hold_go++;
            wait_idle();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
